[sv/ile_pkg.sv]
// Shared types, field widths and codes for the indexed list engine.
package ile_pkg;

	localparam int OP_W     = 4;
	localparam int INDEX_W  = 10;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 31;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 11;

	// Request layout on the input tdata, lowest bit first.
	localparam int IN_OP_LSB    = 0;
	localparam int IN_INDEX_LSB = IN_OP_LSB + OP_W;
	localparam int IN_VALUE_LSB = IN_INDEX_LSB + INDEX_W;
	localparam int IN_COUNT_LSB = IN_VALUE_LSB + VALUE_W;
	localparam int IN_BITS      = IN_COUNT_LSB + COUNT_W;
	localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

	// Result layout on the output tdata, lowest bit first.
	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_READ_LSB   = OUT_STATUS_LSB + STATUS_W;
	localparam int OUT_POS_LSB    = OUT_READ_LSB + VALUE_W;
	localparam int OUT_LEN_LSB    = OUT_POS_LSB + INDEX_W;
	localparam int OUT_BITS       = OUT_LEN_LSB + LEN_W;
	localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_WRITE  = 4'd0;
	localparam logic [OP_W-1:0] OP_READ   = 4'd1;
	localparam logic [OP_W-1:0] OP_BACK   = 4'd2;
	localparam logic [OP_W-1:0] OP_FRONT  = 4'd3;
	localparam logic [OP_W-1:0] OP_REMOVE = 4'd4;
	localparam logic [OP_W-1:0] OP_INSERT = 4'd5;
	localparam logic [OP_W-1:0] OP_PUSH   = 4'd6;
	localparam logic [OP_W-1:0] OP_FIND   = 4'd7;
	localparam logic [OP_W-1:0] OP_ROTL   = 4'd8;
	localparam logic [OP_W-1:0] OP_ROTR   = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	typedef logic [4:0] act_t;

	localparam act_t A_NONE     = 5'd0;
	localparam act_t A_LOAD     = 5'd1;
	localparam act_t A_CLR      = 5'd2;
	localparam act_t A_SET_ST   = 5'd3;
	localparam act_t A_WRITE    = 5'd4;
	localparam act_t A_RD_IDX   = 5'd5;
	localparam act_t A_RD_BACK  = 5'd6;
	localparam act_t A_RD_FRONT = 5'd7;
	localparam act_t A_CAP_RD   = 5'd8;
	localparam act_t A_RM_RD    = 5'd9;
	localparam act_t A_RM_WR    = 5'd10;
	localparam act_t A_RM_END   = 5'd11;
	localparam act_t A_IN_INIT  = 5'd12;
	localparam act_t A_IN_RD    = 5'd13;
	localparam act_t A_IN_WR    = 5'd14;
	localparam act_t A_IN_END   = 5'd15;
	localparam act_t A_PUSH     = 5'd16;
	localparam act_t A_FD_INIT  = 5'd17;
	localparam act_t A_FD_RD    = 5'd18;
	localparam act_t A_FD_HIT   = 5'd19;
	localparam act_t A_FD_NEXT  = 5'd20;
	localparam act_t A_DIV_INIT = 5'd21;
	localparam act_t A_DIV_STEP = 5'd22;
	localparam act_t A_RT_INIT  = 5'd23;
	localparam act_t A_RT_RD    = 5'd24;
	localparam act_t A_RT_WR    = 5'd25;
	localparam act_t A_CP_RD    = 5'd26;
	localparam act_t A_CP_WR    = 5'd27;
	localparam act_t A_OUT      = 5'd28;

	typedef struct packed {
		act_t                act;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            rng_bad;
		logic            ins_bad;
		logic            full;
		logic            empty;
		logic            rm_more;
		logic            in_more;
		logic            fd_more;
		logic            hit;
		logic            div_last;
		logic            k_zero;
		logic            i_last;
		logic            clr_last;
		logic            out_free;
	} flags_t;

endpackage

[sv/ile_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/ile_ctrl.sv]
// Sequencer that steps each list request through the datapath.
module ile_ctrl
	import ile_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  logic   cfg_fire,
	input  flags_t flags,
	output cmd_t   cmd
);

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_EXEC   = 5'd2;
	localparam logic [4:0] S_CAP    = 5'd3;
	localparam logic [4:0] S_RM_CAP = 5'd4;
	localparam logic [4:0] S_RM_RD  = 5'd5;
	localparam logic [4:0] S_RM_WR  = 5'd6;
	localparam logic [4:0] S_IN_RD  = 5'd7;
	localparam logic [4:0] S_IN_WR  = 5'd8;
	localparam logic [4:0] S_FD_RD  = 5'd9;
	localparam logic [4:0] S_FD_CMP = 5'd10;
	localparam logic [4:0] S_DIV    = 5'd11;
	localparam logic [4:0] S_RT_K   = 5'd12;
	localparam logic [4:0] S_RT_RD  = 5'd13;
	localparam logic [4:0] S_RT_WR  = 5'd14;
	localparam logic [4:0] S_CP_RD  = 5'd15;
	localparam logic [4:0] S_CP_WR  = 5'd16;
	localparam logic [4:0] S_FIN    = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_nx;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '{act: A_NONE, status: ST_OK};
		state_nx = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.act = A_CLR;
				if (flags.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.act  = A_LOAD;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nx = S_FIN;
				unique case (flags.op)
					OP_WRITE: begin
						if (flags.rng_bad) begin
							cmd = '{act: A_SET_ST, status: ST_RANGE};
						end else begin
							cmd.act = A_WRITE;
						end
					end
					OP_READ: begin
						if (flags.rng_bad) begin
							cmd = '{act: A_SET_ST, status: ST_RANGE};
						end else begin
							cmd.act  = A_RD_IDX;
							state_nx = S_CAP;
						end
					end
					OP_BACK, OP_FRONT: begin
						if (flags.empty) begin
							cmd = '{act: A_SET_ST, status: ST_EMPTY};
						end else begin
							cmd.act  = (flags.op == OP_BACK) ? A_RD_BACK : A_RD_FRONT;
							state_nx = S_CAP;
						end
					end
					OP_REMOVE: begin
						if (flags.rng_bad) begin
							cmd = '{act: A_SET_ST, status: ST_RANGE};
						end else begin
							cmd.act  = A_RD_IDX;
							state_nx = S_RM_CAP;
						end
					end
					OP_INSERT: begin
						if (flags.ins_bad) begin
							cmd = '{act: A_SET_ST, status: ST_RANGE};
						end else if (flags.full) begin
							cmd = '{act: A_SET_ST, status: ST_FULL};
						end else begin
							cmd.act  = A_IN_INIT;
							state_nx = S_IN_RD;
						end
					end
					OP_PUSH: begin
						if (flags.full) begin
							cmd = '{act: A_SET_ST, status: ST_FULL};
						end else begin
							cmd.act = A_PUSH;
						end
					end
					OP_FIND: begin
						cmd.act  = A_FD_INIT;
						state_nx = S_FD_RD;
					end
					OP_ROTL, OP_ROTR: begin
						if (flags.empty) begin
							cmd = '{act: A_SET_ST, status: ST_EMPTY};
						end else begin
							cmd.act  = A_DIV_INIT;
							state_nx = S_DIV;
						end
					end
					default: begin
						cmd.act = A_NONE;
					end
				endcase
			end
			S_CAP: begin
				cmd.act  = A_CAP_RD;
				state_nx = S_FIN;
			end
			S_RM_CAP: begin
				cmd.act  = A_CAP_RD;
				state_nx = S_RM_RD;
			end
			S_RM_RD: begin
				if (flags.rm_more) begin
					cmd.act  = A_RM_RD;
					state_nx = S_RM_WR;
				end else begin
					cmd.act  = A_RM_END;
					state_nx = S_FIN;
				end
			end
			S_RM_WR: begin
				cmd.act  = A_RM_WR;
				state_nx = S_RM_RD;
			end
			S_IN_RD: begin
				if (flags.in_more) begin
					cmd.act  = A_IN_RD;
					state_nx = S_IN_WR;
				end else begin
					cmd.act  = A_IN_END;
					state_nx = S_FIN;
				end
			end
			S_IN_WR: begin
				cmd.act  = A_IN_WR;
				state_nx = S_IN_RD;
			end
			S_FD_RD: begin
				if (flags.fd_more) begin
					cmd.act  = A_FD_RD;
					state_nx = S_FD_CMP;
				end else begin
					state_nx = S_FIN;
				end
			end
			S_FD_CMP: begin
				if (flags.hit) begin
					cmd.act  = A_FD_HIT;
					state_nx = S_FIN;
				end else begin
					cmd.act  = A_FD_NEXT;
					state_nx = S_FD_RD;
				end
			end
			S_DIV: begin
				cmd.act = A_DIV_STEP;
				if (flags.div_last) begin
					state_nx = S_RT_K;
				end
			end
			S_RT_K: begin
				if (flags.k_zero) begin
					state_nx = S_FIN;
				end else begin
					cmd.act  = A_RT_INIT;
					state_nx = S_RT_RD;
				end
			end
			S_RT_RD: begin
				cmd.act  = A_RT_RD;
				state_nx = S_RT_WR;
			end
			S_RT_WR: begin
				cmd.act  = A_RT_WR;
				state_nx = flags.i_last ? S_CP_RD : S_RT_RD;
			end
			S_CP_RD: begin
				cmd.act  = A_CP_RD;
				state_nx = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.act  = A_CP_WR;
				state_nx = flags.i_last ? S_FIN : S_CP_RD;
			end
			S_FIN: begin
				if (flags.out_free) begin
					cmd.act  = A_OUT;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else if (cfg_fire) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

[sv/ile_dp.sv]
// Datapath: list store, scratch store, length, pointers, divider and result register.
module ile_dp
	import ile_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   cfg_fire,
	input  logic [LEN_W-1:0]       cfg_data,
	input  cmd_t                   cmd,
	output flags_t                 flags,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > INDEX_W) ? LW : INDEX_W;
	localparam int JW = $clog2(COUNT_W);

	logic [OP_W-1:0]     op_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [VALUE_W-1:0]  val_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [LW-1:0]       len_q;
	logic [LW-1:0]       i_q;
	logic [AW-1:0]       src_q;
	logic [LW-1:0]       rem_q;
	logic [JW-1:0]       j_q;
	logic [STATUS_W-1:0] status_q;
	logic [VALUE_W-1:0]  rd_q;
	logic [INDEX_W-1:0]  pos_q;
	logic                out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [CW-1:0]      idx_x;
	logic [CW-1:0]      len_x;
	logic [LW-1:0]      i_inc;
	logic [LW-1:0]      i_dec;
	logic [LW-1:0]      len_dec;
	logic [LW-1:0]      k_init;
	logic [LW-1:0]      src_inc;
	logic [LW:0]        div_t;
	logic [LW:0]        div_sub;
	logic [LW-1:0]      cfg_len;

	logic               m_we;
	logic [AW-1:0]      m_waddr;
	logic [VALUE_W-1:0] m_wdata;
	logic               m_re;
	logic [AW-1:0]      m_raddr;
	logic [VALUE_W-1:0] m_rdata;
	logic               s_we;
	logic               s_re;
	logic [VALUE_W-1:0] s_rdata;

	assign idx_x   = CW'(idx_q);
	assign len_x   = CW'(len_q);
	assign i_inc   = i_q + LW'(1);
	assign i_dec   = i_q - LW'(1);
	assign len_dec = len_q - LW'(1);
	assign k_init  = (op_q == OP_ROTR) ? (len_q - rem_q) : rem_q;
	assign src_inc = LW'(src_q) + LW'(1);
	assign div_t   = {rem_q, cnt_q[COUNT_W-1]};
	assign div_sub = div_t - {1'b0, len_q};
	assign cfg_len = (32'(cfg_data) > 32'(CAPACITY)) ? LW'(CAPACITY) : LW'(cfg_data);

	always_comb begin
		flags.op       = op_q;
		flags.rng_bad  = idx_x >= len_x;
		flags.ins_bad  = idx_x > len_x;
		flags.full     = len_q == LW'(CAPACITY);
		flags.empty    = len_q == '0;
		flags.rm_more  = ({1'b0, i_q} + (LW+1)'(1)) < {1'b0, len_q};
		flags.in_more  = CW'(i_q) > idx_x;
		flags.fd_more  = i_q < len_q;
		flags.hit      = m_rdata == val_q;
		flags.div_last = j_q == '0;
		flags.k_zero   = rem_q == '0;
		flags.i_last   = i_q == len_dec;
		flags.clr_last = i_q == LW'(CAPACITY - 1);
		flags.out_free = !out_valid_q || m_tready;
	end

	// Memory port steering for each action.
	always_comb begin
		m_we    = 1'b0;
		m_waddr = i_q[AW-1:0];
		m_wdata = m_rdata;
		m_re    = 1'b0;
		m_raddr = i_q[AW-1:0];
		s_we    = 1'b0;
		s_re    = 1'b0;
		unique case (cmd.act)
			A_CLR: begin
				m_we    = 1'b1;
				m_wdata = '0;
			end
			A_WRITE: begin
				m_we    = 1'b1;
				m_waddr = idx_x[AW-1:0];
				m_wdata = val_q;
			end
			A_RD_IDX: begin
				m_re    = 1'b1;
				m_raddr = idx_x[AW-1:0];
			end
			A_RD_BACK: begin
				m_re    = 1'b1;
				m_raddr = len_dec[AW-1:0];
			end
			A_RD_FRONT: begin
				m_re    = 1'b1;
				m_raddr = '0;
			end
			A_RM_RD: begin
				m_re    = 1'b1;
				m_raddr = i_inc[AW-1:0];
			end
			A_RM_WR, A_IN_WR: begin
				m_we = 1'b1;
			end
			A_RM_END: begin
				// The pointer sits on the last slot, which is freed.
				m_we    = 1'b1;
				m_wdata = '0;
			end
			A_IN_RD: begin
				m_re    = 1'b1;
				m_raddr = i_dec[AW-1:0];
			end
			A_IN_END: begin
				m_we    = 1'b1;
				m_waddr = idx_x[AW-1:0];
				m_wdata = val_q;
			end
			A_PUSH: begin
				m_we    = 1'b1;
				m_waddr = len_q[AW-1:0];
				m_wdata = val_q;
			end
			A_FD_RD: begin
				m_re = 1'b1;
			end
			A_RT_RD: begin
				m_re    = 1'b1;
				m_raddr = src_q;
			end
			A_RT_WR: begin
				s_we = 1'b1;
			end
			A_CP_RD: begin
				s_re = 1'b1;
			end
			A_CP_WR: begin
				m_we    = 1'b1;
				m_wdata = s_rdata;
			end
			default: begin
				m_we = 1'b0;
			end
		endcase
	end

	ile_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_main (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	ile_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_scratch (
		.clk   (clk),
		.we    (s_we),
		.waddr (i_q[AW-1:0]),
		.wdata (m_rdata),
		.re    (s_re),
		.raddr (i_q[AW-1:0]),
		.rdata (s_rdata)
	);

	// Control registers: length, pointer and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_fire) begin
			len_q <= cfg_len;
			i_q   <= '0;
		end else begin
			if (cmd.act == A_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.act)
				A_CLR: begin
					i_q <= flags.clr_last ? '0 : i_inc;
				end
				A_RD_IDX: begin
					i_q <= LW'(idx_q);
				end
				A_RM_WR, A_FD_NEXT, A_CP_WR: begin
					i_q <= i_inc;
				end
				A_RM_END: begin
					len_q <= len_dec;
				end
				A_IN_INIT: begin
					i_q <= len_q;
				end
				A_IN_WR: begin
					i_q <= i_dec;
				end
				A_IN_END, A_PUSH: begin
					len_q <= len_q + LW'(1);
				end
				A_FD_INIT, A_RT_INIT: begin
					i_q <= '0;
				end
				A_RT_WR: begin
					i_q <= flags.i_last ? '0 : i_inc;
				end
				default: begin
					i_q <= i_q;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (cmd.act)
			A_LOAD: begin
				op_q     <= s_tdata[IN_OP_LSB +: OP_W];
				idx_q    <= s_tdata[IN_INDEX_LSB +: INDEX_W];
				val_q    <= s_tdata[IN_VALUE_LSB +: VALUE_W];
				cnt_q    <= s_tdata[IN_COUNT_LSB +: COUNT_W];
				status_q <= ST_OK;
				rd_q     <= '0;
				pos_q    <= '0;
			end
			A_SET_ST: begin
				status_q <= cmd.status;
			end
			A_CAP_RD: begin
				rd_q <= m_rdata;
			end
			A_FD_INIT: begin
				status_q <= ST_NOTFOUND;
			end
			A_FD_HIT: begin
				status_q <= ST_OK;
				pos_q    <= INDEX_W'(i_q);
			end
			A_DIV_INIT: begin
				rem_q <= '0;
				j_q   <= JW'(COUNT_W - 1);
			end
			A_DIV_STEP: begin
				// One restoring step of count modulo length per cycle.
				rem_q <= div_sub[LW] ? div_t[LW-1:0] : div_sub[LW-1:0];
				cnt_q <= {cnt_q[COUNT_W-2:0], 1'b0};
				j_q   <= j_q - JW'(1);
			end
			A_RT_INIT: begin
				src_q <= k_init[AW-1:0];
			end
			A_RT_WR: begin
				src_q <= (src_inc == len_q) ? '0 : src_inc[AW-1:0];
			end
			A_OUT: begin
				out_data_q <= OUT_TDATA_W'({LEN_W'(len_q), pos_q, rd_q, status_q});
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[sv/indexed_list_engine.sv]
// Top level of the indexed list engine: ordered list of signed 32-bit entries.
//
//  Channel   Direction  Handshake              Carries
//  s_*       in         s_tvalid / s_tready    one list request
//  m_*       out        m_tvalid / m_tready    one result per request
//  cfg_*     in         cfg_valid / cfg_ready  initial length register
//
// A request is taken only while the sequencer is idle and is worked on alone.
// Write, push, undefined operations and every range, full or empty rejection go
// straight to the result; read, back and front capture the read data; remove
// shifts the entries above the index down and frees the last slot; insert
// shifts the entries from the index up and writes the value in; find compares
// each entry until a match; rotate runs a 31-step restoring modulo, then,
// unless the count reduces to zero, a copy through the scratch store and back,
// one memory port each way. Reset and every register write start a clearing
// pass over the store, during which no request is taken. A full result
// register holds the sequencer in its last step until m_tready frees it; a
// result waiting there does not hold up the acceptance of the next request.
module indexed_list_engine
	import ile_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// operation[3:0], index[13:4], value[45:14], count[76:46], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status[2:0], read_value[34:3], found_position[44:35], current_length[55:45]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LEN_W-1:0]       cfg_data
);

	cmd_t   cmd;
	flags_t flags;
	logic   cfg_fire;

	// The register is always writable; a write reloads the length and
	// restarts the clearing pass.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;

	ile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cfg_fire (cfg_fire),
		.flags    (flags),
		.cmd      (cmd)
	);

	ile_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_fire (cfg_fire),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.flags    (flags),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
